### hdl/hmdg_pkg.sv
package hmdg_pkg;

    localparam int HEIGHT_W     = 24;
    localparam int PIX_W        = 8;
    localparam int FW_W         = 12;
    localparam int FH_W         = 13;
    localparam int ROW_W        = 12;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int QPTR_W       = 2;
    localparam int QUEUE_DEPTH  = 1 << QPTR_W;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [FW_W-1:0] RESET_FRAME_WIDTH  = 12'd2048;
    localparam logic [FH_W-1:0] RESET_FRAME_HEIGHT = 13'd2048;

    typedef logic signed [HEIGHT_W-1:0] t_height;
    typedef logic        [HEIGHT_W-1:0] t_mag;

    localparam t_height PEAK_RESET = {1'b1, {(HEIGHT_W-1){1'b0}}};

    // One classified pixel on its way from the front to the back.
    typedef struct packed {
        t_height cur;
        t_height left;
        t_height up;
        logic    use_left;
        logic    use_up;
        logic    last;
    } t_item;

endpackage

### hdl/hmdg_front.sv
module hmdg_front
    import hmdg_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [PIX_W-1:0]       i_blue_byte,
    input  logic [PIX_W-1:0]       i_green_byte,
    input  logic [PIX_W-1:0]       i_red_byte,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_clear,
    output logic                   o_push,
    output t_item                  o_item,
    input  logic                   i_full
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [FW_W-1:0]  r_width;
    logic [FH_W-1:0]  r_height_cfg;
    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [AW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;
    t_height          r_left;

    logic             r_f_valid;
    t_height          r_f_cur;
    t_height          r_f_left;
    logic             r_f_use_left;
    logic             r_f_use_up;
    logic             r_f_last;
    t_height          r_up_rd;

    t_height          r_mem [MAX_WIDTH];

    logic [WW-1:0]    eff_w;
    logic [FH_W-1:0]  eff_h;
    logic             accept;
    logic             col_last;
    logic             row_last;
    logic             wr_width;
    logic             wr_height;
    t_height          cur;

    // Subtracting 2^23 from the raw 24-bit value only flips its top bit.
    assign cur = {~i_blue_byte[PIX_W-1], i_blue_byte[PIX_W-2:0], i_green_byte, i_red_byte};

    always_comb begin
        if (r_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_width);
        end
        if (r_height_cfg == '0) begin
            eff_h = FH_W'(1);
        end else if (32'(r_height_cfg) > 32'(HEIGHT_LIMIT)) begin
            eff_h = FH_W'(HEIGHT_LIMIT);
        end else begin
            eff_h = r_height_cfg;
        end
    end

    assign col_last = (WW'(r_col) + WW'(1)) == eff_w;
    assign row_last = ({1'b0, r_row} + FH_W'(1)) == eff_h;

    always_comb begin
        n_col = r_col + AW'(1);
        n_row = r_row;
        if (col_last) begin
            n_col = '0;
            n_row = row_last ? '0 : r_row + ROW_W'(1);
        end
    end

    assign wr_width  = i_cfg_we && (i_cfg_index == REG_FRAME_WIDTH)
                       && (i_cfg_data[FW_W-1:0] != r_width);
    assign wr_height = i_cfg_we && (i_cfg_index == REG_FRAME_HEIGHT)
                       && (i_cfg_data != r_height_cfg);
    assign o_clear   = wr_width || wr_height;

    assign o_push     = r_f_valid && !i_full;
    assign o_in_ready = !r_f_valid || !i_full;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= RESET_FRAME_WIDTH;
            r_height_cfg <= RESET_FRAME_HEIGHT;
            r_col        <= '0;
            r_row        <= '0;
            r_left       <= '0;
            r_f_valid    <= 1'b0;
        end else begin
            if (wr_width) begin
                r_width <= i_cfg_data[FW_W-1:0];
            end
            if (wr_height) begin
                r_height_cfg <= i_cfg_data;
            end
            if (o_clear) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_left <= cur;
            end
            if (accept) begin
                r_f_valid <= 1'b1;
            end else if (o_push) begin
                r_f_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f_cur      <= cur;
            r_f_left     <= r_left;
            r_f_use_left <= r_col != '0;
            r_f_use_up   <= r_row != '0;
            r_f_last     <= col_last && row_last;
        end
    end

    // The read returns the previous row's entry before this pixel replaces it.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up_rd      <= r_mem[r_col];
            r_mem[r_col] <= cur;
        end
    end

    always_comb begin
        o_item.cur      = r_f_cur;
        o_item.left     = r_f_left;
        o_item.up       = r_up_rd;
        o_item.use_left = r_f_use_left;
        o_item.use_up   = r_f_use_up;
        o_item.last     = r_f_last;
    end

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_col) < eff_w)
        else $error("column counter outside the frame width");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_row} < eff_h)
        else $error("row counter outside the frame height");

    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_valid && i_full |=> r_f_valid)
        else $error("front stage dropped a pixel while the queue was full");

endmodule

### hdl/hmdg_queue.sv
module hmdg_queue
    import hmdg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_head,
    output logic  o_empty
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = r_count == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count beyond its depth");

endmodule

### hdl/hmdg_back.sv
module hmdg_back
    import hmdg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_clear,
    input  logic    i_empty,
    input  t_item   i_head,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_height o_height,
    output t_height o_max_height,
    output t_mag    o_max_gradient,
    output logic    o_gradient_valid,
    output logic    o_frame_end
);

    logic    advance;

    logic    r_b1_valid;
    t_height r_b1_cur;
    t_mag    r_b1_mag_left;
    t_mag    r_b1_mag_up;
    logic    r_b1_use_left;
    logic    r_b1_use_up;
    logic    r_b1_last;

    logic    r_b2_valid;
    t_height r_b2_cur;
    t_mag    r_b2_mag;
    logic    r_b2_any;
    logic    r_b2_last;

    t_height r_peak_height;
    t_mag    r_peak_gradient;
    logic    r_gradient_seen;

    logic    r_o_valid;
    t_height r_o_height;
    logic    r_o_last;

    t_mag    mag_left;
    t_mag    mag_up;
    t_mag    n_mag;
    t_height n_peak_height;
    t_mag    n_peak_gradient;
    logic    n_gradient_seen;

    // The whole back end moves together whenever the output slot frees up.
    assign advance = !r_o_valid || i_out_ready;
    assign o_pop   = advance && !i_empty;

    function automatic t_mag abs_diff(input t_height a, input t_height b);
        logic signed [HEIGHT_W:0] d_ab;
        logic signed [HEIGHT_W:0] d_ba;
        d_ab = {a[HEIGHT_W-1], a} - {b[HEIGHT_W-1], b};
        d_ba = {b[HEIGHT_W-1], b} - {a[HEIGHT_W-1], a};
        return d_ab[HEIGHT_W] ? d_ba[HEIGHT_W-1:0] : d_ab[HEIGHT_W-1:0];
    endfunction

    assign mag_left = abs_diff(i_head.cur, i_head.left);
    assign mag_up   = abs_diff(i_head.cur, i_head.up);

    always_comb begin
        if (r_b1_use_left && r_b1_use_up) begin
            n_mag = (r_b1_mag_up > r_b1_mag_left) ? r_b1_mag_up : r_b1_mag_left;
        end else if (r_b1_use_up) begin
            n_mag = r_b1_mag_up;
        end else begin
            n_mag = r_b1_mag_left;
        end
    end

    // The first difference ever seen is taken as is; later ones must beat the peak.
    always_comb begin
        n_peak_height   = (r_b2_cur > r_peak_height) ? r_b2_cur : r_peak_height;
        n_peak_gradient = r_peak_gradient;
        n_gradient_seen = r_gradient_seen || r_b2_any;
        if (r_b2_any && (!r_gradient_seen || r_b2_mag > r_peak_gradient)) begin
            n_peak_gradient = r_b2_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid      <= 1'b0;
            r_b2_valid      <= 1'b0;
            r_o_valid       <= 1'b0;
            r_peak_height   <= PEAK_RESET;
            r_peak_gradient <= '0;
            r_gradient_seen <= 1'b0;
        end else if (i_clear) begin
            r_peak_height   <= PEAK_RESET;
            r_peak_gradient <= '0;
            r_gradient_seen <= 1'b0;
        end else if (advance) begin
            r_b1_valid <= !i_empty;
            r_b2_valid <= r_b1_valid;
            r_o_valid  <= r_b2_valid;
            if (r_b2_valid) begin
                r_peak_height   <= n_peak_height;
                r_peak_gradient <= n_peak_gradient;
                r_gradient_seen <= n_gradient_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_b1_cur      <= i_head.cur;
            r_b1_mag_left <= mag_left;
            r_b1_mag_up   <= mag_up;
            r_b1_use_left <= i_head.use_left;
            r_b1_use_up   <= i_head.use_up;
            r_b1_last     <= i_head.last;
            r_b2_cur      <= r_b1_cur;
            r_b2_mag      <= n_mag;
            r_b2_any      <= r_b1_use_left || r_b1_use_up;
            r_b2_last     <= r_b1_last;
            r_o_height    <= r_b2_cur;
            r_o_last      <= r_b2_last;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_height         = r_o_height;
    assign o_max_height     = r_peak_height;
    assign o_max_gradient   = r_peak_gradient;
    assign o_gradient_valid = r_gradient_seen;
    assign o_frame_end      = r_o_last;

    a_no_gradient_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_gradient_seen |-> r_peak_gradient == '0)
        else $error("gradient peak set before any difference was taken");

    a_peak_covers_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> r_peak_height >= r_o_height)
        else $error("height above the running maximum");

    a_gradient_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gradient_seen && !i_clear |=> r_gradient_seen)
        else $error("gradient flag fell without a size change");

endmodule

### hdl/heightmap_decode_gradient_max.sv
// Path: a pixel passes the front register, the queue, the difference stage, the max
// stage and the output register. Throughput: one pixel per cycle unless the output
// is held off; the running-maximum update is a loop on its own registers.
// Reset: synchronous active-low; frame size returns to 2048 x 2048 and the maxima clear.
// The line store is not cleared; its entries are used only where the row above was already written.
module heightmap_decode_gradient_max
    import hmdg_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [PIX_W-1:0]       i_blue_byte,
    input  logic [PIX_W-1:0]       i_green_byte,
    input  logic [PIX_W-1:0]       i_red_byte,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [HEIGHT_W-1:0] o_height,
    output logic signed [HEIGHT_W-1:0] o_max_height,
    output logic [HEIGHT_W-1:0]    o_max_gradient,
    output logic                   o_gradient_valid,
    output logic                   o_frame_end,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic  clear;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    t_item push_item;
    t_item head_item;

    hmdg_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_blue_byte  (i_blue_byte),
        .i_green_byte (i_green_byte),
        .i_red_byte   (i_red_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_clear      (clear),
        .o_push       (push),
        .o_item       (push_item),
        .i_full       (full)
    );

    hmdg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head_item),
        .o_empty (empty)
    );

    hmdg_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_clear          (clear),
        .i_empty          (empty),
        .i_head           (head_item),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_height         (o_height),
        .o_max_height     (o_max_height),
        .o_max_gradient   (o_max_gradient),
        .o_gradient_valid (o_gradient_valid),
        .o_frame_end      (o_frame_end)
    );

endmodule

### dv/heightmap_decode_gradient_max_test.sv
`timescale 1ns / 1ps

module heightmap_decode_gradient_max_test;
    import hmdg_pkg::*;

    localparam int MAX_W          = 2048;
    localparam int DRAIN_CYCLES   = 10;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    // Indexes that decode to no register; writes there must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_pixel;

    typedef struct {
        t_height height;
        t_height max_height;
        t_mag    max_gradient;
        logic    gradient_ok;
        logic    frame_end;
    } t_hm_result;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   pix_valid = 1'b0;
    logic                   pix_ready;
    t_pixel                 offered = '0;
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    t_height                res_height;
    t_height                res_max_height;
    t_mag                   res_max_gradient;
    logic                   res_gradient_valid;
    logic                   res_frame_end;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    t_pixel     pending_q[$];
    t_hm_result expected_q[$];

    int send_gap_pct   = 18;
    int recv_stall_pct = 75;
    int hold_reqs      = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int mismatch_count = 0;
    int unsigned walk_raw = 0;

    // Shadow of the decoder state.
    logic [FW_W-1:0] cfg_width;
    logic [FH_W-1:0] cfg_height;
    t_height         prev_row [MAX_W];
    t_height         left_h;
    int              col_cnt;
    int              row_cnt;
    t_height         peak_h;
    t_mag            peak_g;
    logic            grad_seen;

    heightmap_decode_gradient_max #(
        .MAX_WIDTH(MAX_W)
    ) u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (pix_valid),
        .o_in_ready       (pix_ready),
        .i_blue_byte      (offered.blue),
        .i_green_byte     (offered.green),
        .i_red_byte       (offered.red),
        .o_out_valid      (res_valid),
        .i_out_ready      (res_ready),
        .o_height         (res_height),
        .o_max_height     (res_max_height),
        .o_max_gradient   (res_max_gradient),
        .o_gradient_valid (res_gradient_valid),
        .o_frame_end      (res_frame_end),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic void restart_tracking();
        col_cnt   = 0;
        row_cnt   = 0;
        peak_h    = PEAK_RESET;
        peak_g    = '0;
        grad_seen = 1'b0;
    endfunction

    function automatic void reset_decoder();
        cfg_width  = RESET_FRAME_WIDTH;
        cfg_height = RESET_FRAME_HEIGHT;
        left_h     = '0;
        restart_tracking();
    endfunction

    function automatic void apply_size_write(input logic [CFG_INDEX_W-1:0] idx,
                                             input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_FRAME_WIDTH: begin
                if (data[FW_W-1:0] != cfg_width) begin
                    cfg_width = data[FW_W-1:0];
                    restart_tracking();
                end
            end
            REG_FRAME_HEIGHT: begin
                if (data[FH_W-1:0] != cfg_height) begin
                    cfg_height = data[FH_W-1:0];
                    restart_tracking();
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void note_step(input t_height a, input t_height b);
        int d;
        d = int'(a) - int'(b);
        if (d < 0) d = -d;
        if (!grad_seen || d > int'(peak_g)) begin
            peak_g    = t_mag'(d);
            grad_seen = 1'b1;
        end
    endfunction

    function automatic t_hm_result decode_pixel(input t_pixel px);
        int         w;
        int         h;
        int         c;
        t_height    cur;
        t_hm_result r;
        w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_W) ? MAX_W : int'(cfg_width));
        h = (cfg_height == 0) ? 1 :
            ((cfg_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(cfg_height));
        // Subtracting half scale from the raw value just flips its top bit.
        cur = {~px.blue[PIX_W-1], px.blue[PIX_W-2:0], px.green, px.red};
        if (col_cnt >= w) col_cnt = 0;
        if (row_cnt >= h) row_cnt = 0;
        c = col_cnt;
        if (cur > peak_h) peak_h = cur;
        if (c > 0) note_step(cur, left_h);
        if (row_cnt > 0) note_step(cur, prev_row[c]);
        prev_row[c] = cur;
        left_h      = cur;
        r.frame_end = (c + 1 == w) && (row_cnt + 1 == h);
        if (c + 1 == w) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 == h) ? 0 : row_cnt + 1;
        end else begin
            col_cnt = c + 1;
        end
        r.height       = cur;
        r.max_height   = peak_h;
        r.max_gradient = grad_seen ? peak_g : '0;
        r.gradient_ok  = grad_seen;
        return r;
    endfunction

    // Mostly a random walk so the gradient maximum climbs gradually, with some
    // full-range noise and the occasional extreme level.
    function automatic t_pixel next_pixel(input int noise_pct);
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(99);
        if (pick < 3) begin
            walk_raw = ($urandom_range(1) != 0) ? 32'hFFFFFF : 32'h0;
        end else if (pick < 3 + noise_pct) begin
            walk_raw = $urandom & 32'hFFFFFF;
        end else begin
            span     = 32'd1 << $urandom_range(0, 15);
            walk_raw = (walk_raw + $urandom_range(0, 2 * span) - span) & 32'hFFFFFF;
        end
        return t_pixel'(walk_raw[HEIGHT_W-1:0]);
    endfunction

    task automatic compare_field(input string name, input logic [HEIGHT_W-1:0] want,
                                 input logic [HEIGHT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_size_write(idx, data);
    endtask

    task automatic set_frame(input int w, input int h);
        logic [CFG_DATA_W-1:0] wdata;
        wdata       = CFG_DATA_W'(w);
        // The bit above the width field must be dropped by the block.
        wdata[FW_W] = 1'($urandom_range(1));
        if ($urandom_range(1) != 0) begin
            cfg_write(REG_FRAME_WIDTH, wdata);
            cfg_write(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
        end else begin
            cfg_write(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
            cfg_write(REG_FRAME_WIDTH, wdata);
        end
        if ($urandom_range(2) == 0) begin
            cfg_write(REG_FRAME_WIDTH, wdata);
            cfg_write(($urandom_range(1) != 0) ? REG_SPARE_2 : REG_SPARE_3,
                      CFG_DATA_W'($urandom));
        end
    endtask

    task automatic queue_random(input int count, input int noise_pct);
        @(negedge clk);
        for (int i = 0; i < count; i++) pending_q.push_back(next_pixel(noise_pct));
    endtask

    // Waits until every pixel has gone in and every result has come out.
    task automatic wait_idle();
        do @(negedge clk);
        while (pending_q.size() != 0 || pix_valid || expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Pixel driver.
    always @(posedge clk) begin
        if (!rst_n) begin
            pix_valid <= 1'b0;
        end else begin
            if (pix_valid && pix_ready) expected_q.push_back(decode_pixel(offered));
            if (!pix_valid || pix_ready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    offered   <= pending_q.pop_front();
                    pix_valid <= 1'b1;
                end else begin
                    pix_valid <= 1'b0;
                end
            end
        end
    end

    // Result acceptance, with an occasional long hold-off.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else if (hold_left != 0) begin
            res_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_reqs) begin
            res_ready   <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_reqs;
        end else begin
            res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result monitor.
    always @(posedge clk) begin : result_check
        t_hm_result want;
        if (rst_n && res_valid && res_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got height %h",
                         $time, res_height);
                mismatch_count++;
            end else begin
                want = expected_q.pop_front();
                compare_field("height", want.height, res_height);
                compare_field("max_height", want.max_height, res_max_height);
                compare_field("max_gradient", want.max_gradient, res_max_gradient);
                compare_field("gradient_valid", HEIGHT_W'(want.gradient_ok),
                              HEIGHT_W'(res_gradient_valid));
                compare_field("frame_end", HEIGHT_W'(want.frame_end),
                              HEIGHT_W'(res_frame_end));
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk) begin
        if (!rst_n || (pix_valid && pix_ready) || (res_valid && res_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
            $display("FAIL heightmap_decode_gradient_max");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int n;
        int w;
        int h;
        int noise;
        reset_decoder();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset frame size; extreme levels give the largest possible step.
        @(negedge clk);
        pending_q.push_back(t_pixel'(24'h000000));
        pending_q.push_back(t_pixel'(24'hFFFFFF));
        pending_q.push_back(t_pixel'(24'h800000));
        pending_q.push_back(t_pixel'(24'h7FFFFF));
        wait_idle();

        // Small frame: wraps a frame and uses both neighbours.
        set_frame(3, 2);
        queue_random(7, 50);
        wait_idle();

        // Single column: only the upper neighbour exists.
        set_frame(1, 3);
        queue_random(4, 50);
        wait_idle();

        // Zero sizes act as one pixel per frame, so no gradient ever shows up.
        set_frame(0, 0);
        cfg_write(REG_FRAME_WIDTH, '0);
        cfg_write(REG_SPARE_2, '1);
        cfg_write(REG_SPARE_3, '1);
        queue_random(3, 50);
        wait_idle();

        for (int ph = 0; ph < 12; ph++) begin
            case (ph / 4)
                0: begin
                    send_gap_pct   = 18;
                    recv_stall_pct = 75;
                end
                1: begin
                    send_gap_pct   = 75;
                    recv_stall_pct = 18;
                end
                default: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            n     = $urandom_range(120, 190);
            w     = $urandom_range(1, 40);
            h     = $urandom_range(1, 6);
            noise = $urandom_range(0, 15);
            case (ph)
                1: begin
                    w = 1;
                    h = 8191;
                end
                3: begin
                    // Oversized width, clamped to the widest row.
                    w = 4095;
                    h = 1;
                end
                6: begin
                    w = MAX_W;
                    h = HEIGHT_LIMIT;
                end
                10: begin
                    w = 0;
                    h = 0;
                end
                4, 8: begin
                    // Same sizes again, so the maxima carry over.
                    w = cfg_width;
                    h = cfg_height;
                end
                default: begin
                end
            endcase
            set_frame(w, h);
            if (ph == 6) begin
                queue_random(n / 2, noise);
                wait_idle();
                n = n - n / 2;
            end
            queue_random(n, noise);
            if (ph == 9) begin
                repeat (20) @(negedge clk);
                hold_reqs++;
            end
            wait_idle();
        end

        if (mismatch_count == 0 && expected_q.size() == 0) begin
            $display("PASS heightmap_decode_gradient_max");
        end else begin
            $display("FAIL heightmap_decode_gradient_max");
        end
        $finish;
    end

endmodule
